// ----- sv/rai_pkg.sv -----
`default_nettype none

package rai_pkg;

   // Number of tested axes, starting with x; values above three act as three
   localparam int DIMENSIONS = 3;
   localparam int AXES       = (DIMENSIONS < 3) ? DIMENSIONS : 3;
   localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;

   // Q16.16 words and the widths of the ray parameter divide
   localparam int WORD_W         = 32;
   localparam int FRAC_W         = 16;
   localparam int DIFF_W         = WORD_W + 1;
   localparam int NUM_W          = WORD_W + FRAC_W;
   localparam int QUO_W          = WORD_W;
   localparam int T_W            = WORD_W - 1;
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
   localparam int PROD_W         = 2 * WORD_W;
   localparam int COORD_W        = NUM_W + 1;

   // Register map: lower corner x, y, z then upper corner x, y, z
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_BASE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_BASE = 3'd3;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [AXES-1:0] vec_type;

   // Per-ray control and payload that travels down the pipeline
   typedef struct packed {
      logic            valid;
      logic            org_in_box;
      logic [AXES-1:0] left;
      logic [AXES-1:0] right;
      logic [AXES-1:0] t_ok;
      vec_type         org;
      vec_type         dir;
   } ray_info_type;

endpackage

`default_nettype wire

// ----- sv/rai_front.sv -----
`default_nettype none

module rai_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire rai_pkg::vec_type           org,
   input  wire rai_pkg::vec_type           dir,
   input  wire rai_pkg::vec_type           box_min,
   input  wire rai_pkg::vec_type           box_max,
   output rai_pkg::ray_info_type           info_out,
   output logic [rai_pkg::AXES-1:0][rai_pkg::NUM_W-1:0]  num_out,
   output logic [rai_pkg::AXES-1:0][rai_pkg::WORD_W-1:0] den_out
);

   rai_pkg::ray_info_type s1_info_in, s1_info_ff;
   logic [rai_pkg::AXES-1:0][rai_pkg::DIFF_W-1:0] s1_diff_in, s1_diff_ff;

   rai_pkg::ray_info_type s2_info_in, s2_info_ff;
   logic [rai_pkg::AXES-1:0][rai_pkg::NUM_W-1:0]  s2_num_in, s2_num_ff;
   logic [rai_pkg::AXES-1:0][rai_pkg::WORD_W-1:0] s2_den_in, s2_den_ff;

   // Classify each axis and take the distance to its candidate plane
   always_comb begin
      logic lt, gt;
      logic signed [rai_pkg::DIFF_W-1:0] d_min, d_max;
      s1_info_in        = '0;
      s1_info_in.valid  = in_valid;
      s1_info_in.org    = org;
      s1_info_in.dir    = dir;
      for (int i = 0; i < rai_pkg::AXES; i++) begin
         lt = $signed(org[i]) < $signed(box_min[i]);
         gt = $signed(org[i]) > $signed(box_max[i]);
         d_min = $signed({box_min[i][rai_pkg::WORD_W-1], box_min[i]})
               - $signed({org[i][rai_pkg::WORD_W-1], org[i]});
         d_max = $signed({box_max[i][rai_pkg::WORD_W-1], box_max[i]})
               - $signed({org[i][rai_pkg::WORD_W-1], org[i]});
         s1_info_in.left[i]  = lt;
         s1_info_in.right[i] = !lt && gt;
         s1_diff_in[i]       = lt ? d_min : d_max;
      end
      s1_info_in.org_in_box = ~|(s1_info_in.left | s1_info_in.right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_info_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_info_ff <= s1_info_in;
         s1_diff_ff <= s1_diff_in;
      end
   end

   // Form unsigned dividend and divisor; flag axes whose t is not negative
   // (a pointing-away axis still counts when its quotient truncates to zero)
   always_comb begin
      logic [rai_pkg::DIFF_W-1:0] mag;
      logic [rai_pkg::WORD_W-1:0] dmag;
      logic                       dneg, dnz;
      s2_info_in = s1_info_ff;
      for (int i = 0; i < rai_pkg::AXES; i++) begin
         mag  = s1_diff_ff[i][rai_pkg::DIFF_W-1] ? (~s1_diff_ff[i] + 1'b1) : s1_diff_ff[i];
         dneg = s1_info_ff.dir[i][rai_pkg::WORD_W-1];
         dnz  = |s1_info_ff.dir[i];
         dmag = dneg ? (~s1_info_ff.dir[i] + 1'b1) : s1_info_ff.dir[i];
         s2_num_in[i] = {mag[rai_pkg::WORD_W-1:0], {rai_pkg::FRAC_W{1'b0}}};
         s2_info_in.t_ok[i] = dnz && ((s1_info_ff.left[i] && !dneg)
                                   || (s1_info_ff.right[i] && dneg)
                                   || ((s1_info_ff.left[i] || s1_info_ff.right[i])
                                       && (s2_num_in[i] < rai_pkg::NUM_W'(dmag))));
         s2_den_in[i] = dnz ? dmag : rai_pkg::WORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_info_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_info_ff <= s2_info_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
      end
   end

   assign info_out = s2_info_ff;
   assign num_out  = s2_num_ff;
   assign den_out  = s2_den_ff;

endmodule

`default_nettype wire

// ----- sv/rai_div.sv -----
`default_nettype none

module rai_div (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        advance,
   input  wire rai_pkg::ray_info_type                       info_in,
   input  wire logic [rai_pkg::AXES-1:0][rai_pkg::NUM_W-1:0]  num_in,
   input  wire logic [rai_pkg::AXES-1:0][rai_pkg::WORD_W-1:0] den_in,
   output rai_pkg::ray_info_type                            info_out,
   output logic [rai_pkg::AXES-1:0][rai_pkg::QUO_W-1:0]     quo_out,
   output logic [rai_pkg::AXES-1:0]                         ovf_out
);

   localparam int S = rai_pkg::DIV_STAGES;
   localparam int A = rai_pkg::AXES;
   localparam int W = rai_pkg::WORD_W;

   rai_pkg::ray_info_type info_in_s [S];
   rai_pkg::ray_info_type info_ff   [S];
   logic [A-1:0][W-1:0]   rem_src [S];
   logic [A-1:0][W-1:0]   rem_in  [S];
   logic [A-1:0][W-1:0]   rem_ff  [S];
   logic [A-1:0][W-1:0]   low_src [S];
   logic [A-1:0][W-1:0]   low_in  [S];
   logic [A-1:0][W-1:0]   low_ff  [S];
   logic [A-1:0][rai_pkg::QUO_W-1:0] quo_src [S];
   logic [A-1:0][rai_pkg::QUO_W-1:0] quo_in  [S];
   logic [A-1:0][rai_pkg::QUO_W-1:0] quo_ff  [S];
   logic [A-1:0][W-1:0]   den_src [S];
   logic [A-1:0][W-1:0]   den_ff  [S];
   logic [A-1:0]          ovf_src [S];
   logic [A-1:0]          ovf_ff  [S];

   for (genvar s = 0; s < S; s++) begin : g_stage
      // Load the first stage from the dividend; later stages from the one before
      if (s == 0) begin : g_first
         always_comb begin
            info_in_s[s] = info_in;
            den_src[s]   = den_in;
            for (int i = 0; i < A; i++) begin
               rem_src[s][i] = W'(num_in[i][rai_pkg::NUM_W-1:W]);
               low_src[s][i] = num_in[i][W-1:0];
               quo_src[s][i] = '0;
               ovf_src[s][i] = W'(num_in[i][rai_pkg::NUM_W-1:W]) >= den_in[i];
            end
         end
      end else begin : g_next
         always_comb begin
            info_in_s[s] = info_ff[s-1];
            den_src[s]   = den_ff[s-1];
            rem_src[s]   = rem_ff[s-1];
            low_src[s]   = low_ff[s-1];
            quo_src[s]   = quo_ff[s-1];
            ovf_src[s]   = ovf_ff[s-1];
         end
      end

      // Retire BITS_PER_STAGE quotient bits by shift and conditional subtract
      always_comb begin
         logic [W:0] r2;
         rem_in[s] = rem_src[s];
         low_in[s] = low_src[s];
         quo_in[s] = quo_src[s];
         for (int i = 0; i < A; i++) begin
            for (int b = 0; b < rai_pkg::BITS_PER_STAGE; b++) begin
               r2 = {rem_in[s][i], low_in[s][i][W-1]};
               low_in[s][i] = {low_in[s][i][W-2:0], 1'b0};
               if (r2 >= {1'b0, den_src[s][i]}) begin
                  rem_in[s][i] = W'(r2 - {1'b0, den_src[s][i]});
                  quo_in[s][i] = {quo_in[s][i][rai_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[s][i] = r2[W-1:0];
                  quo_in[s][i] = {quo_in[s][i][rai_pkg::QUO_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            info_ff[s].valid <= 1'b0;
         end else if (advance) begin
            info_ff[s] <= info_in_s[s];
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            quo_ff[s]  <= quo_in[s];
            den_ff[s]  <= den_src[s];
            ovf_ff[s]  <= ovf_src[s];
         end
      end
   end

   assign info_out = info_ff[S-1];
   assign quo_out  = quo_ff[S-1];
   assign ovf_out  = ovf_ff[S-1];

endmodule

`default_nettype wire

// ----- sv/rai_back.sv -----
`default_nettype none

module rai_back (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     advance,
   input  wire rai_pkg::ray_info_type                    info_in,
   input  wire logic [rai_pkg::AXES-1:0][rai_pkg::QUO_W-1:0] quo_in,
   input  wire logic [rai_pkg::AXES-1:0]                 ovf_in,
   input  wire rai_pkg::vec_type                         box_min,
   input  wire rai_pkg::vec_type                         box_max,
   output logic                                          out_valid,
   output logic                                          out_hit,
   output logic                                          out_inside,
   output rai_pkg::vec_type                              out_coord
);

   localparam int A = rai_pkg::AXES;

   // Entry plane selection
   rai_pkg::ray_info_type           ra_info_ff;
   logic [rai_pkg::T_W-1:0]         ra_t_in, ra_t_ff;
   logic [rai_pkg::AXIS_W-1:0]      ra_best_in, ra_best_ff;
   logic                            ra_ok_in, ra_ok_ff;

   // Products
   rai_pkg::ray_info_type           rb_info_ff;
   logic [rai_pkg::AXIS_W-1:0]      rb_best_ff;
   logic                            rb_ok_ff;
   logic signed [rai_pkg::PROD_W-1:0] rb_prod_in [A];
   logic signed [rai_pkg::PROD_W-1:0] rb_prod_ff [A];

   // Coordinates
   rai_pkg::ray_info_type           rc_info_ff;
   logic [rai_pkg::AXIS_W-1:0]      rc_best_ff;
   logic                            rc_ok_ff;
   logic signed [rai_pkg::COORD_W-1:0] rc_coord_in [A];
   logic signed [rai_pkg::COORD_W-1:0] rc_coord_ff [A];

   // Result
   logic                            rd_hit_in;
   rai_pkg::vec_type                rd_coord_in;
   logic                            rd_valid_ff, rd_hit_ff, rd_inside_ff;
   rai_pkg::vec_type                rd_coord_ff;

   // Saturate t and keep the largest, lowest axis on a tie
   always_comb begin
      logic [rai_pkg::T_W-1:0] t [A];
      int best;
      for (int i = 0; i < A; i++) begin
         t[i] = (ovf_in[i] || quo_in[i][rai_pkg::QUO_W-1]) ? {rai_pkg::T_W{1'b1}}
                                                           : quo_in[i][rai_pkg::T_W-1:0];
      end
      best = 0;
      for (int i = 1; i < A; i++) begin
         if (info_in.t_ok[i] && (!info_in.t_ok[best] || (t[best] < t[i]))) begin
            best = i;
         end
      end
      ra_best_in = rai_pkg::AXIS_W'(best);
      ra_t_in    = t[best];
      ra_ok_in   = info_in.t_ok[best];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ra_info_ff.valid <= 1'b0;
      end else if (advance) begin
         ra_info_ff <= info_in;
         ra_t_ff    <= ra_t_in;
         ra_best_ff <= ra_best_in;
         ra_ok_ff   <= ra_ok_in;
      end
   end

   // Scale every direction by the chosen t
   always_comb begin
      for (int i = 0; i < A; i++) begin
         rb_prod_in[i] = $signed({1'b0, ra_t_ff}) * $signed(ra_info_ff.dir[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_info_ff.valid <= 1'b0;
      end else if (advance) begin
         rb_info_ff <= ra_info_ff;
         rb_best_ff <= ra_best_ff;
         rb_ok_ff   <= ra_ok_ff;
         rb_prod_ff <= rb_prod_in;
      end
   end

   // Step from the origin; the chosen axis sits on its plane
   always_comb begin
      logic signed [rai_pkg::PROD_W-1:0] sh;
      for (int i = 0; i < A; i++) begin
         sh = rb_prod_ff[i] >>> rai_pkg::FRAC_W;
         if (rai_pkg::AXIS_W'(i) == rb_best_ff) begin
            rc_coord_in[i] = rb_info_ff.left[i]
               ? rai_pkg::COORD_W'($signed(box_min[i]))
               : rai_pkg::COORD_W'($signed(box_max[i]));
         end else begin
            rc_coord_in[i] = rai_pkg::COORD_W'($signed(rb_info_ff.org[i]))
                           + $signed(sh[rai_pkg::COORD_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_info_ff.valid <= 1'b0;
      end else if (advance) begin
         rc_info_ff  <= rb_info_ff;
         rc_best_ff  <= rb_best_ff;
         rc_ok_ff    <= rb_ok_ff;
         rc_coord_ff <= rc_coord_in;
      end
   end

   // Range check the other axes and build the result
   always_comb begin
      logic in_box;
      in_box = 1'b1;
      for (int i = 0; i < A; i++) begin
         if (rai_pkg::AXIS_W'(i) != rc_best_ff) begin
            if (rc_coord_ff[i] < rai_pkg::COORD_W'($signed(box_min[i]))
                || rc_coord_ff[i] > rai_pkg::COORD_W'($signed(box_max[i]))) begin
               in_box = 1'b0;
            end
         end
      end
      rd_hit_in = rc_info_ff.org_in_box || (rc_ok_ff && in_box);
      for (int i = 0; i < A; i++) begin
         if (rc_info_ff.org_in_box) begin
            rd_coord_in[i] = rc_info_ff.org[i];
         end else if (rd_hit_in) begin
            rd_coord_in[i] = rc_coord_ff[i][rai_pkg::WORD_W-1:0];
         end else begin
            rd_coord_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (advance) begin
         rd_valid_ff  <= rc_info_ff.valid;
         rd_hit_ff    <= rd_hit_in;
         rd_inside_ff <= rc_info_ff.org_in_box;
         rd_coord_ff  <= rd_coord_in;
      end
   end

   assign out_valid  = rd_valid_ff;
   assign out_hit    = rd_hit_ff;
   assign out_inside = rd_inside_ff;
   assign out_coord  = rd_coord_ff;

endmodule

`default_nettype wire

// ----- sv/ray_aabb_intersect.sv -----
// Ray versus axis-aligned box test in signed Q16.16.
// Write the box corners through the csr_ port (index 0..2 lower corner x/y/z,
// 3..5 upper corner x/y/z) while no ray is in flight; writes take effect at once.
// Present a ray on the req_ channel (origin and direction); it is taken at a
// clock edge where req_valid is high and req_stall is low.
// Each ray yields one transaction on the rsp_ channel: hit, origin_inside and the
// hit point, which is zero on a miss.
// From acceptance to rsp_valid a ray passes two setup stages, eight
// stages of the restoring divide that forms t (four quotient bits per stage),
// then plane selection, multiply, coordinate add and range check.
// Throughput is one ray per cycle while rsp_stall does not hold the pipeline.
// Reset clears the box to zero and empties the pipeline.
// While rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated.
`default_nettype none

module ray_aabb_intersect (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_origin_x,
   input  wire logic [31:0] req_origin_y,
   input  wire logic [31:0] req_origin_z,
   input  wire logic [31:0] req_dir_x,
   input  wire logic [31:0] req_dir_y,
   input  wire logic [31:0] req_dir_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_hit,
   output logic             rsp_origin_inside,
   output logic [31:0]      rsp_hit_x,
   output logic [31:0]      rsp_hit_y,
   output logic [31:0]      rsp_hit_z,
   input  wire logic        csr_write,
   input  wire logic [rai_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int A = rai_pkg::AXES;

   rai_pkg::word_type     box_min_ff [A];
   rai_pkg::word_type     box_max_ff [A];
   rai_pkg::vec_type      box_min_vec, box_max_vec;
   rai_pkg::vec_type      org_vec, dir_vec, coord_vec;
   logic [2:0][31:0]      org_all, dir_all, out_all;
   logic                  advance;

   rai_pkg::ray_info_type front_info, div_info;
   logic [A-1:0][rai_pkg::NUM_W-1:0]  front_num;
   logic [A-1:0][rai_pkg::WORD_W-1:0] front_den;
   logic [A-1:0][rai_pkg::QUO_W-1:0]  div_quo;
   logic [A-1:0]                      div_ovf;

   // Store box corners
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < A; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (csr_write) begin
         for (int i = 0; i < A; i++) begin
            if (csr_index == rai_pkg::CSR_BOX_MIN_BASE + rai_pkg::CSR_INDEX_W'(i)) begin
               box_min_ff[i] <= csr_data;
            end
            if (csr_index == rai_pkg::CSR_BOX_MAX_BASE + rai_pkg::CSR_INDEX_W'(i)) begin
               box_max_ff[i] <= csr_data;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < A; i++) begin
         box_min_vec[i] = box_min_ff[i];
         box_max_vec[i] = box_max_ff[i];
      end
   end

   // Gather axis ports
   assign org_all = {req_origin_z, req_origin_y, req_origin_x};
   assign dir_all = {req_dir_z, req_dir_y, req_dir_x};
   assign org_vec = org_all[A-1:0];
   assign dir_vec = dir_all[A-1:0];

   // Hold every stage while a finished result waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   rai_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .org      (org_vec),
      .dir      (dir_vec),
      .box_min  (box_min_vec),
      .box_max  (box_max_vec),
      .info_out (front_info),
      .num_out  (front_num),
      .den_out  (front_den)
   );

   rai_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .info_in  (front_info),
      .num_in   (front_num),
      .den_in   (front_den),
      .info_out (div_info),
      .quo_out  (div_quo),
      .ovf_out  (div_ovf)
   );

   rai_back u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .info_in    (div_info),
      .quo_in     (div_quo),
      .ovf_in     (div_ovf),
      .box_min    (box_min_vec),
      .box_max    (box_max_vec),
      .out_valid  (rsp_valid),
      .out_hit    (rsp_hit),
      .out_inside (rsp_origin_inside),
      .out_coord  (coord_vec)
   );

   // Spread the hit point over the axis ports; unused axes read zero
   assign out_all   = 96'(coord_vec);
   assign rsp_hit_x = out_all[0];
   assign rsp_hit_y = out_all[1];
   assign rsp_hit_z = out_all[2];

   a_inside_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_origin_inside |-> rsp_hit)
      else $error("origin inside without hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_x == 32'd0 && rsp_hit_y == 32'd0
                                && rsp_hit_z == 32'd0 && !rsp_origin_inside)
      else $error("miss with nonzero point");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free output");

   a_inside_x_in_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_origin_inside |-> $signed(rsp_hit_x) >= $signed(box_min_ff[0])
                                         && $signed(rsp_hit_x) <= $signed(box_max_ff[0]))
      else $error("origin inside but x outside box");

endmodule

`default_nettype wire
